// ----- design/cts_pkg.sv -----
// cts_pkg: types and constants shared by the cluster task scheduler
// item structs for both channels, event kinds, register indexes and reset values
// depends on nothing
`default_nettype none

package cts_pkg;

  // event kinds carried in event_kind
  typedef enum logic [2:0] {
    EV_PLACED    = 3'd0,
    EV_FAILED    = 3'd1,
    EV_COMPLETED = 3'd2,
    EV_SUMMARY   = 3'd3,
    EV_DROPPED   = 3'd4
  } ev_kind_e;

  // configuration register indexes
  localparam logic [3:0] CFG_PROC_COUNT = 4'd0;
  localparam logic [3:0] CFG_CORE_TABLE = 4'd1;

  // register reset values
  localparam logic [3:0]  PROC_COUNT_RESET = 4'd8;
  localparam logic [39:0] CORE_TABLE_RESET = 40'd851234808600;

  // request kinds
  localparam logic REQ_SUBMIT = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] task_id;
    logic [3:0]  need_procs;
    logic [4:0]  need_cores;
    logic [9:0]  duration;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] event_task_id;
    logic [7:0]  proc_mask;
    logic [7:0]  busy_cores;
    logic [7:0]  total_cores;
    logic [15:0] tick_number;
    logic        last;
  } out_item_t;

  // queued task as held in the wait memory
  typedef struct packed {
    logic [15:0] task_id;
    logic [3:0]  need_procs;
    logic [4:0]  need_cores;
    logic [9:0]  duration;
  } wait_ent_t;

  // buffered result, summary fields are added on the way out
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] task_id;
    logic [7:0]  mask;
  } ev_ent_t;

  // total cores of processor p, zero beyond the eighth
  function automatic logic [4:0] total_of(input logic [39:0] tbl, input int p);
    logic [4:0] t;
    t = 5'd0;
    if (p < 8) t = tbl[5*p +: 5];
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- design/cluster_task_first_fit_scheduler_core.sv -----
// cluster_task_first_fit_scheduler_core: fifo intake, first-fit core allocation
// submit: no result unless the queue is full, then one dropped item from the drop state
// tick: accept, then per queue entry a read and a place or fail, ending at an empty queue
//   or a blocked head, then a walk over the active slots with a read and release check per
//   busy slot, the summary, then results read out of the result buffer memory, held by stalls
// one item at a time; reset clears counters and valid bits, loads free counts from the
//   reset core table; the memories need no clearing pass
`default_nettype none

module cluster_task_first_fit_scheduler_core #(
  parameter int MAX_PROCS    = 8,
  parameter int WAIT_DEPTH   = 16,
  parameter int ACTIVE_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire cts_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output cts_pkg::out_item_t      out_item_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [3:0]         cfg_index_i,
  input  wire logic [39:0]        cfg_data_i
);
  import cts_pkg::*;

  localparam int WA      = $clog2(WAIT_DEPTH);
  localparam int WC      = $clog2(WAIT_DEPTH + 1);
  localparam int AA      = $clog2(ACTIVE_DEPTH);
  localparam int MAX_RES = WAIT_DEPTH + ACTIVE_DEPTH + 1;
  localparam int EA      = $clog2(MAX_RES);
  localparam int EC      = $clog2(MAX_RES + 1);
  localparam int AW      = 16 + 5 + 10 + 16 + MAX_PROCS;
  localparam logic [4:0] MaxProcsW = 5'(MAX_PROCS);

  typedef struct packed {
    logic [15:0]          task_id;
    logic [4:0]           cores;
    logic [9:0]           duration;
    logic [15:0]          start;
    logic [MAX_PROCS-1:0] mask;
  } act_ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DROP, S_DRD, S_DEV, S_RRD, S_REV, S_SUM, S_ORD, S_OLD
  } state_e;

  state_e         state_q;
  logic [WA-1:0]  head_q;
  logic [WC-1:0]  count_q;
  logic [15:0]    tick_q;
  logic [ACTIVE_DEPTH-1:0] valid_q;
  logic [4:0]     free_q [MAX_PROCS];
  logic [3:0]     proc_count_q;
  logic [39:0]    core_table_q;
  logic [AA-1:0]  rel_q;
  logic [EC-1:0]  ecnt_q;
  logic [EC-1:0]  oidx_q;
  logic [7:0]     busy_q, total_q;
  logic [15:0]    drop_id_q;
  logic           out_valid_q;
  out_item_t      out_q;

  // memory ports
  logic           wq_we, wq_re;
  logic [WA-1:0]  wq_waddr;
  wait_ent_t      wq_wdata, wq_rdata;
  logic           at_we, at_re;
  act_ent_t       at_wdata, at_rdata;
  logic           ev_we, ev_re;
  ev_ent_t        ev_wdata, ev_rdata;

  // helpers
  logic [4:0]           np;
  logic [4:0]           cap;
  logic [4:0]           picked;
  logic [MAX_PROCS-1:0] pick_mask;
  logic                 slot_found;
  logic [AA-1:0]        free_slot;
  logic                 head_fail, place_ok, rel_hit, out_free, in_acc, out_load;
  logic [15:0]          elapsed;
  logic [8:0]           busy_sum, total_sum;
  logic [7:0]           busy_now, total_now;
  logic [WC:0]          tail_sum;
  logic [WA-1:0]        tail, head_nx;
  logic [AA-1:0]        rel_nx;

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = out_free && ((state_q == S_DROP) || (state_q == S_OLD));

  // processors in use, clamped to the instance size
  assign np = ({1'b0, proc_count_q} > MaxProcsW) ? MaxProcsW : {1'b0, proc_count_q};

  // queue tail and head wrap
  always_comb begin
    tail_sum = (WC+1)'(head_q) + (WC+1)'(count_q);
    if (tail_sum >= (WC+1)'(WAIT_DEPTH)) tail_sum = tail_sum - (WC+1)'(WAIT_DEPTH);
    tail    = tail_sum[WA-1:0];
    head_nx = (head_q == WA'(WAIT_DEPTH - 1)) ? '0 : head_q + 1'b1;
    rel_nx  = rel_q + 1'b1;
  end

  // capacity count and first-fit pick for the head task
  always_comb begin
    cap       = '0;
    picked    = '0;
    pick_mask = '0;
    for (int p = 0; p < MAX_PROCS; p++) begin
      if (5'(p) < np) begin
        if (total_of(core_table_q, p) >= wq_rdata.need_cores) cap = cap + 1'b1;
        if (free_q[p] >= wq_rdata.need_cores && picked < {1'b0, wq_rdata.need_procs}) begin
          pick_mask[p] = 1'b1;
          picked       = picked + 1'b1;
        end
      end
    end
    head_fail = (wq_rdata.need_procs == 4'd0) || (cap < {1'b0, wq_rdata.need_procs});
  end

  // lowest free active slot
  always_comb begin
    slot_found = 1'b0;
    free_slot  = '0;
    for (int s = ACTIVE_DEPTH - 1; s >= 0; s--) begin
      if (!valid_q[s]) begin
        slot_found = 1'b1;
        free_slot  = AA'(s);
      end
    end
    place_ok = !head_fail && slot_found && (picked >= {1'b0, wq_rdata.need_procs});
  end

  // release check on the slot just read
  assign elapsed = tick_q - at_rdata.start;
  assign rel_hit = (elapsed == {6'd0, at_rdata.duration});

  // busy and total cores over processors in use
  always_comb begin
    busy_sum  = '0;
    total_sum = '0;
    for (int p = 0; p < MAX_PROCS; p++) begin
      if (5'(p) < np) begin
        total_sum = total_sum + 9'(total_of(core_table_q, p));
        if (free_q[p] < total_of(core_table_q, p))
          busy_sum = busy_sum + 9'(total_of(core_table_q, p) - free_q[p]);
      end
    end
    busy_now  = busy_sum[8] ? 8'hFF : busy_sum[7:0];
    total_now = total_sum[8] ? 8'hFF : total_sum[7:0];
  end

  // memory port control
  always_comb begin
    wq_we    = in_acc && (in_item_i.req_type == REQ_SUBMIT) && (count_q < WC'(WAIT_DEPTH));
    wq_waddr = tail;
    wq_wdata = '{task_id: in_item_i.task_id, need_procs: in_item_i.need_procs,
                 need_cores: in_item_i.need_cores, duration: in_item_i.duration};
    wq_re    = (state_q == S_DRD) && (count_q != '0);

    at_we    = (state_q == S_DEV) && place_ok;
    at_wdata = '{task_id: wq_rdata.task_id, cores: wq_rdata.need_cores,
                 duration: wq_rdata.duration, start: tick_q, mask: pick_mask};
    at_re    = (state_q == S_RRD) && valid_q[rel_q];

    ev_we    = 1'b0;
    ev_wdata = '{kind: EV_SUMMARY, task_id: 16'd0, mask: 8'd0};
    case (state_q)
      S_DEV: begin
        if (head_fail) begin
          ev_we    = 1'b1;
          ev_wdata = '{kind: EV_FAILED, task_id: wq_rdata.task_id, mask: 8'd0};
        end else if (place_ok) begin
          ev_we    = 1'b1;
          ev_wdata = '{kind: EV_PLACED, task_id: wq_rdata.task_id,
                       mask: 8'(pick_mask)};
        end
      end
      S_REV: begin
        if (rel_hit) begin
          ev_we    = 1'b1;
          ev_wdata = '{kind: EV_COMPLETED, task_id: at_rdata.task_id,
                       mask: 8'(at_rdata.mask)};
        end
      end
      S_SUM: ev_we = 1'b1;
      default: ev_we = 1'b0;
    endcase
    ev_re = (state_q == S_ORD);
  end

  cts_ram #(.WIDTH($bits(wait_ent_t)), .DEPTH(WAIT_DEPTH)) u_wait_ram (
    .clk_i, .we_i(wq_we), .waddr_i(wq_waddr), .wdata_i(wq_wdata),
    .re_i(wq_re), .raddr_i(head_q), .rdata_o(wq_rdata)
  );

  cts_ram #(.WIDTH(AW), .DEPTH(ACTIVE_DEPTH)) u_active_ram (
    .clk_i, .we_i(at_we), .waddr_i(free_slot), .wdata_i(at_wdata),
    .re_i(at_re), .raddr_i(rel_q), .rdata_o(at_rdata)
  );

  cts_ram #(.WIDTH($bits(ev_ent_t)), .DEPTH(MAX_RES)) u_event_ram (
    .clk_i, .we_i(ev_we), .waddr_i(ecnt_q[EA-1:0]), .wdata_i(ev_wdata),
    .re_i(ev_re), .raddr_i(oidx_q[EA-1:0]), .rdata_o(ev_rdata)
  );

  // sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      tick_q       <= '0;
      valid_q      <= '0;
      proc_count_q <= PROC_COUNT_RESET;
      core_table_q <= CORE_TABLE_RESET;
      rel_q        <= '0;
      ecnt_q       <= '0;
      oidx_q       <= '0;
      busy_q       <= '0;
      total_q      <= '0;
      drop_id_q    <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      for (int p = 0; p < MAX_PROCS; p++) free_q[p] <= total_of(CORE_TABLE_RESET, p);
    end else begin
      // output valid: set on a new result, cleared once taken
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      // register writes
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_PROC_COUNT) proc_count_q <= cfg_data_i[3:0];
        else if (cfg_index_i == CFG_CORE_TABLE) core_table_q <= cfg_data_i;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_item_i.req_type == REQ_TICK) begin
              tick_q  <= tick_q + 16'd1;
              ecnt_q  <= '0;
              state_q <= S_DRD;
            end else if (count_q < WC'(WAIT_DEPTH)) begin
              count_q <= count_q + 1'b1;
            end else begin
              drop_id_q <= in_item_i.task_id;
              state_q   <= S_DROP;
            end
          end
        end
        S_DROP: begin
          if (out_free) begin
            out_q <= '{event_kind: EV_DROPPED, event_task_id: drop_id_q, proc_mask: 8'd0,
                       busy_cores: busy_now, total_cores: total_now,
                       tick_number: tick_q, last: 1'b1};
            state_q <= S_IDLE;
          end
        end
        // dispatch from the queue head
        S_DRD: begin
          if (count_q == '0) begin
            rel_q   <= '0;
            state_q <= S_RRD;
          end else begin
            state_q <= S_DEV;
          end
        end
        S_DEV: begin
          if (head_fail || place_ok) begin
            head_q  <= head_nx;
            count_q <= count_q - 1'b1;
            ecnt_q  <= ecnt_q + 1'b1;
            state_q <= S_DRD;
            if (place_ok) begin
              valid_q[free_slot] <= 1'b1;
              for (int p = 0; p < MAX_PROCS; p++)
                if (pick_mask[p]) free_q[p] <= free_q[p] - wq_rdata.need_cores;
            end
          end else begin
            // head-of-line blocking
            rel_q   <= '0;
            state_q <= S_RRD;
          end
        end
        // release walk over the active table
        S_RRD: begin
          if (valid_q[rel_q]) begin
            state_q <= S_REV;
          end else if (rel_q == AA'(ACTIVE_DEPTH - 1)) begin
            state_q <= S_SUM;
          end else begin
            rel_q <= rel_nx;
          end
        end
        S_REV: begin
          if (rel_hit) begin
            valid_q[rel_q] <= 1'b0;
            ecnt_q         <= ecnt_q + 1'b1;
            for (int p = 0; p < MAX_PROCS; p++)
              if (at_rdata.mask[p])
                free_q[p] <= ({1'b0, free_q[p]} + {1'b0, at_rdata.cores} > 6'd31)
                             ? 5'd31 : free_q[p] + at_rdata.cores;
          end
          if (rel_q == AA'(ACTIVE_DEPTH - 1)) begin
            state_q <= S_SUM;
          end else begin
            rel_q   <= rel_nx;
            state_q <= S_RRD;
          end
        end
        S_SUM: begin
          busy_q  <= busy_now;
          total_q <= total_now;
          ecnt_q  <= ecnt_q + 1'b1;
          oidx_q  <= '0;
          state_q <= S_ORD;
        end
        // stream buffered results
        S_ORD: state_q <= S_OLD;
        S_OLD: begin
          if (out_free) begin
            out_q <= '{event_kind: ev_rdata.kind, event_task_id: ev_rdata.task_id,
                       proc_mask: ev_rdata.mask, busy_cores: busy_q,
                       total_cores: total_q, tick_number: tick_q,
                       last: (oidx_q == ecnt_q - 1'b1)};
            oidx_q  <= oidx_q + 1'b1;
            state_q <= (oidx_q == ecnt_q - 1'b1) ? S_IDLE : S_ORD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // queue occupancy never exceeds its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= WC'(WAIT_DEPTH)) else $error("wait count overflow");

  // result buffer never exceeds one tick's worth
  a_ecnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecnt_q <= EC'(MAX_RES)) else $error("result buffer overflow");

  // a placement marks its slot busy
  a_place_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    at_we |=> valid_q[$past(free_slot)]) else $error("placed slot not valid");

  // a tick only starts from idle with the result buffer empty
  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_acc && in_item_i.req_type == REQ_TICK)
      |=> (state_q == S_DRD && ecnt_q == '0)) else $error("tick start broken");

endmodule

`default_nettype wire

// ----- design/cts_ram.sv -----
// cts_ram: generic single write port, single read port ram with registered read
// used for the wait queue, the active table and the result buffer; no dependencies
`default_nettype none

module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read, data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- bench/cluster_task_first_fit_scheduler_core_test.sv -----
// testbench for cluster_task_first_fit_scheduler_core: random and directed submits and ticks
// own scheduler prediction checked against every result item; register writes between phases
// depends on cts_pkg and cluster_task_first_fit_scheduler_core
`default_nettype none

module cluster_task_first_fit_scheduler_core_test;
  import cts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         NPROC          = 8;
  localparam int         WDEPTH         = 16;
  localparam int         ADEPTH         = 16;
  localparam int         MAX_EVENTS     = WDEPTH + ADEPTH + 1;
  localparam int         SETTLE_CYCLES  = 200;
  localparam int         CYCLE_LIMIT    = 2000000;
  localparam int         RX_HOLD_CYCLES = 800;
  localparam logic [3:0] CFG_NO_REG     = 4'd9;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i;
  logic [39:0] cfg_data_i;

  cluster_task_first_fit_scheduler_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // scheduler state as predicted
  logic [3:0]  sch_proc_reg;
  logic [39:0] sch_core_tbl;
  wait_ent_t   sch_wait [WDEPTH];
  int          sch_whead, sch_wcount;
  logic [15:0] act_id [ADEPTH];
  logic [4:0]  act_cores [ADEPTH];
  logic [9:0]  act_dur [ADEPTH];
  logic [15:0] act_start [ADEPTH];
  logic [7:0]  act_mask [ADEPTH];
  logic        act_on [ADEPTH];
  int          sch_free [NPROC];
  logic [15:0] sch_tick;

  in_item_t  task_q [$];
  out_item_t event_q [$];
  int        mismatches = 0;
  int        cycles = 0;
  int        rx_hold;
  int        hold_req = 0;
  int        hold_ack;
  logic      tx_hold;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int core_total(int p);
    if (p >= 8) return 0;
    return int'(sch_core_tbl[5*p +: 5]);
  endfunction

  function automatic int procs_used();
    return (sch_proc_reg > NPROC) ? NPROC : int'(sch_proc_reg);
  endfunction

  function automatic void sched_reset();
    sch_proc_reg = PROC_COUNT_RESET;
    sch_core_tbl = CORE_TABLE_RESET;
    sch_whead    = 0;
    sch_wcount   = 0;
    sch_tick     = '0;
    for (int s = 0; s < ADEPTH; s++) act_on[s] = 1'b0;
    for (int p = 0; p < NPROC; p++) sch_free[p] = core_total(p);
  endfunction

  function automatic void add_event(ref out_item_t evs[$], input logic [2:0] kind,
                                    input logic [15:0] id, input logic [7:0] mask);
    out_item_t e;
    e = '0;
    e.event_kind    = kind;
    e.event_task_id = id;
    e.proc_mask     = mask;
    evs.insert(evs.size(), e);
  endfunction

  // work out the result items of one accepted item and queue them
  function automatic void sched_item(in_item_t it);
    out_item_t evs[$];
    int np, cap, slot, picked, busy, tot, h, f;
    logic [7:0] mask;
    bit stop;
    np = procs_used();
    if (it.req_type == REQ_SUBMIT) begin
      if (sch_wcount >= WDEPTH) begin
        add_event(evs, EV_DROPPED, it.task_id, 8'd0);
      end else begin
        sch_wait[(sch_whead + sch_wcount) % WDEPTH] =
          '{task_id: it.task_id, need_procs: it.need_procs,
            need_cores: it.need_cores, duration: it.duration};
        sch_wcount++;
        return;
      end
    end else begin
      sch_tick = sch_tick + 16'd1;
      stop = 1'b0;
      // dispatch from the queue head
      while (sch_wcount > 0 && evs.size() < MAX_EVENTS && !stop) begin
        h = sch_whead;
        cap = 0;
        for (int p = 0; p < np; p++)
          if (core_total(p) >= sch_wait[h].need_cores) cap++;
        if (sch_wait[h].need_procs == 0 || cap < sch_wait[h].need_procs) begin
          add_event(evs, EV_FAILED, sch_wait[h].task_id, 8'd0);
          sch_whead = (h + 1) % WDEPTH;
          sch_wcount--;
        end else begin
          slot = ADEPTH;
          for (int s = ADEPTH - 1; s >= 0; s--) if (!act_on[s]) slot = s;
          mask = '0;
          picked = 0;
          if (slot < ADEPTH) begin
            for (int p = 0; p < np; p++)
              if (picked < sch_wait[h].need_procs && sch_free[p] >= sch_wait[h].need_cores) begin
                mask[p] = 1'b1;
                picked++;
              end
          end
          if (slot == ADEPTH || picked < sch_wait[h].need_procs) begin
            stop = 1'b1;
          end else begin
            for (int p = 0; p < np; p++) if (mask[p]) sch_free[p] -= sch_wait[h].need_cores;
            act_on[slot]    = 1'b1;
            act_id[slot]    = sch_wait[h].task_id;
            act_cores[slot] = sch_wait[h].need_cores;
            act_dur[slot]   = sch_wait[h].duration;
            act_start[slot] = sch_tick;
            act_mask[slot]  = mask;
            add_event(evs, EV_PLACED, sch_wait[h].task_id, mask);
            sch_whead = (h + 1) % WDEPTH;
            sch_wcount--;
          end
        end
      end
      // release finished tasks in slot order
      for (int s = 0; s < ADEPTH && evs.size() < MAX_EVENTS - 1; s++) begin
        if (act_on[s] && (sch_tick - act_start[s]) == {6'd0, act_dur[s]}) begin
          for (int p = 0; p < NPROC; p++)
            if (act_mask[s][p]) begin
              f = sch_free[p] + act_cores[s];
              sch_free[p] = (f > 31) ? 31 : f;
            end
          act_on[s] = 1'b0;
          add_event(evs, EV_COMPLETED, act_id[s], act_mask[s]);
        end
      end
      add_event(evs, EV_SUMMARY, 16'd0, 8'd0);
    end
    // occupancy fields shared by all results of this item
    busy = 0;
    tot  = 0;
    for (int p = 0; p < np; p++) begin
      tot += core_total(p);
      if (sch_free[p] < core_total(p)) busy += core_total(p) - sch_free[p];
    end
    if (busy > 255) busy = 255;
    if (tot > 255) tot = 255;
    foreach (evs[k]) begin
      evs[k].busy_cores  = busy[7:0];
      evs[k].total_cores = tot[7:0];
      evs[k].tick_number = sch_tick;
      evs[k].last        = (k == evs.size() - 1);
      event_q.insert(event_q.size(), evs[k]);
    end
  endfunction

  // sender: bursts from the pending queue with random gaps
  int burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        sched_item(in_item_i);
        void'(task_q.pop_front());
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (task_q.size() > 0 && !tx_hold && gap_left == 0) begin
          in_valid_i <= 1'b1;
          in_item_i  <= task_q[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  // receiver: stall pattern alternating with clean stretches, plus long hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_hold     <= 0;
      hold_ack    <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack    <= hold_req;
      rx_hold     <= RX_HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready_i <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (cycles[6]) begin
      out_ready_i <= ($urandom_range(0, 2) != 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (event_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: kind %0d id %h", out_item_o.event_kind,
                   out_item_o.event_task_id);
      end else begin
        want = event_q.pop_front();
        if (out_item_o.event_kind !== want.event_kind ||
            out_item_o.event_task_id !== want.event_task_id ||
            out_item_o.proc_mask !== want.proc_mask ||
            out_item_o.busy_cores !== want.busy_cores ||
            out_item_o.total_cores !== want.total_cores ||
            out_item_o.tick_number !== want.tick_number ||
            out_item_o.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind %0d id %h mask %h busy %0d total %0d tick %0d last %b",
                     want.event_kind, want.event_task_id, want.proc_mask, want.busy_cores,
                     want.total_cores, want.tick_number, want.last,
                     "\n          got kind %0d id %h mask %h busy %0d total %0d tick %0d last %b",
                     out_item_o.event_kind, out_item_o.event_task_id, out_item_o.proc_mask,
                     out_item_o.busy_cores, out_item_o.total_cores, out_item_o.tick_number,
                     out_item_o.last);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cluster_task_first_fit_scheduler_core_test: FAIL");
      $finish;
    end
  end

  function automatic in_item_t make_task(logic [15:0] id, logic [3:0] procs,
                                         logic [4:0] cores, logic [9:0] dur);
    return '{req_type: REQ_SUBMIT, task_id: id, need_procs: procs,
             need_cores: cores, duration: dur};
  endfunction

  function automatic in_item_t make_tick();
    in_item_t it;
    it = in_item_t'($urandom());
    it.req_type = REQ_TICK;
    return it;
  endfunction

  // append one item to the pending queue
  function automatic void add_item(in_item_t it);
    task_q.insert(task_q.size(), it);
  endfunction

  // random submits and ticks, mostly sane sizes
  task automatic queue_random(int count);
    logic [3:0] procs;
    logic [4:0] cores;
    logic [9:0] dur;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 4) begin
        add_item(make_tick());
      end else begin
        procs = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 3));
        cores = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 8));
        dur   = ($urandom_range(0, 15) == 0) ? 10'($urandom_range(0, 1023))
                                             : 10'($urandom_range(0, 6));
        add_item(make_task(16'($urandom()), procs, cores, dur));
      end
    end
  endtask

  task automatic wait_idle();
    while (task_q.size() > 0 || in_valid_i || event_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [39:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_PROC_COUNT) sch_proc_reg = val[3:0];
    else if (idx == CFG_CORE_TABLE) sch_core_tbl = val;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    tx_hold     = 1'b0;
    sched_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, special tasks, then overflow of the queue
    add_item(make_task(16'h0000, 4'd8, 5'd24, 10'd0));
    add_item(make_task(16'hffff, 4'd0, 5'd1, 10'd1));
    add_item(make_task(16'h1234, 4'd2, 5'd0, 10'd2));
    add_item(make_task(16'h5a5a, 4'd15, 5'd31, 10'd1023));
    add_item(make_task(16'ha5a5, 4'd1, 5'd1, 10'd1023));
    add_item(make_tick());
    add_item(make_tick());
    add_item(make_tick());
    for (int i = 0; i < 17; i++)
      add_item(make_task(16'(16'h0100 + i), 4'd1, 5'd2, 10'(i % 3)));
    add_item(make_tick());
    add_item(make_tick());
    wait_idle();

    // receiver holds off while the sender keeps offering items
    hold_req = hold_req + 1;
    queue_random(40);
    wait_idle();

    // one processor, every core count at its maximum
    write_reg(CFG_PROC_COUNT, 40'd1);
    write_reg(CFG_CORE_TABLE, 40'hff_ffff_ffff);
    queue_random(35);
    wait_idle();

    // processor count above the maximum, random table
    write_reg(CFG_PROC_COUNT, 40'd15);
    write_reg(CFG_CORE_TABLE, {8'd0, 32'($urandom())} | (40'($urandom()) << 32));
    queue_random(35);
    wait_idle();

    // no processors in use, unknown register index ignored
    write_reg(CFG_PROC_COUNT, 40'd0);
    write_reg(CFG_NO_REG, 40'h12_3456_789a);
    queue_random(25);
    wait_idle();

    // all totals zero
    write_reg(CFG_PROC_COUNT, 40'd4);
    write_reg(CFG_CORE_TABLE, 40'd0);
    queue_random(25);
    wait_idle();

    // back to the default setting
    write_reg(CFG_PROC_COUNT, 40'(PROC_COUNT_RESET));
    write_reg(CFG_CORE_TABLE, CORE_TABLE_RESET);
    queue_random(70);
    wait_idle();

    if (mismatches == 0 && event_q.size() == 0) begin
      $display("cluster_task_first_fit_scheduler_core_test: PASS");
    end else begin
      $display("cluster_task_first_fit_scheduler_core_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
